/* rtl/core/hdec_pkg.sv */
// ----------------------------------------------------------------------------
// hdec_pkg
// Shared types, codes and MD5 tables for the hidden AVP decoder.
// ----------------------------------------------------------------------------
package hdec_pkg;

  localparam int BLOCK_BYTES      = 16;
  localparam int HEADER_BYTES     = 6;
  localparam int MAX_RV_BYTES     = 64;
  localparam int MAX_SECRET_BYTES = 16;
  localparam int QUEUE_DEPTH      = 2;
  localparam int CFG_IDX_W        = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SECRET_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECRET_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SECRET_LEN  = 2'd2;

  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_RV    = 2'd1;
  localparam logic [1:0] FUNC_DATA  = 2'd2;

  localparam logic [31:0] MD5_IV0 = 32'h67452301;
  localparam logic [31:0] MD5_IV1 = 32'hefcdab89;
  localparam logic [31:0] MD5_IV2 = 32'h98badcfe;
  localparam logic [31:0] MD5_IV3 = 32'h10325476;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_SHORT  = 2'd1,
    ST_BIGLEN = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] attr_type;
    logic [9:0]  avp_length;
    logic [6:0]  rv_length;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    status_t    status;
    logic       last;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_RV    = 2'd1,
    CMD_DATA  = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [15:0] attr_type;
    logic [9:0]  value_len;
    status_t     err;
    logic [9:0]  idx;
    logic        last;
    logic [7:0]  data;
  } cmd_t;

  typedef struct packed {
    logic       we;
    logic [5:0] idx;
    logic [7:0] wbyte;
    logic       go;
    logic       first;
  } md5_ctl_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_FILL,
    BK_FLUSH,
    BK_GO,
    BK_HASH,
    BK_KEY,
    BK_PROC,
    BK_EMIT2
  } bk_state_t;

  function automatic logic [31:0] md5_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] md5_s(input logic [5:0] i);
    logic [4:0] s;
    case ({i[5:4], i[1:0]})
      4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
      4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  default: s = 5'd21;
    endcase
    return s;
  endfunction

  function automatic logic [3:0] md5_g(input logic [5:0] i);
    logic [3:0] g;
    case (i[5:4])
      2'd0:    g = i[3:0];
      2'd1:    g = 4'((i * 5) + 1);
      2'd2:    g = 4'((i * 3) + 5);
      default: g = 4'(i * 7);
    endcase
    return g;
  endfunction

endpackage

/* rtl/core/hdec_fifo.sv */
// ----------------------------------------------------------------------------
// hdec_fifo
// Small register queue with full and empty flags.
// ----------------------------------------------------------------------------
module hdec_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = hdec_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + CW'(do_push) - CW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wdata;
    end
  end

endmodule

/* rtl/core/hdec_front.sv */
// ----------------------------------------------------------------------------
// hdec_front
// Accepts input beats, tracks AVP framing and queues commands.
// ----------------------------------------------------------------------------
module hdec_front #(
  parameter int MAX_RV_BYTES = hdec_pkg::MAX_RV_BYTES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  hdec_pkg::in_item_t in_item,
  output logic              in_full,
  output logic              cmd_push,
  output hdec_pkg::cmd_t    cmd_item,
  input  logic              cmd_full
);

  localparam int CW = $clog2(MAX_RV_BYTES + 1);

  logic [9:0]    vlen_r, vlen_nxt, cnt_r, cnt_nxt;
  logic [CW-1:0] rvlen_r, rvlen_nxt, rvcnt_r, rvcnt_nxt;
  logic          accept;
  logic [8:0]    rl9, max9;

  assign in_full = cmd_full;
  assign accept  = in_push && !cmd_full;
  assign rl9     = 9'(in_item.rv_length);
  assign max9    = 9'(MAX_RV_BYTES);

  always_comb begin
    vlen_nxt  = vlen_r;
    cnt_nxt   = cnt_r;
    rvlen_nxt = rvlen_r;
    rvcnt_nxt = rvcnt_r;
    cmd_push  = 1'b0;
    cmd_item  = '0;
    cmd_item.attr_type = in_item.attr_type;
    cmd_item.data      = in_item.data_byte;
    cmd_item.idx       = cnt_r;
    cmd_item.last      = ((cnt_r + 10'd1) == vlen_r);
    if (in_item.avp_length >= 10'(hdec_pkg::HEADER_BYTES)) begin
      cmd_item.value_len = in_item.avp_length - 10'(hdec_pkg::HEADER_BYTES);
    end
    cmd_item.err = (in_item.avp_length < 10'(hdec_pkg::HEADER_BYTES + 2)) ?
                   hdec_pkg::ST_SHORT : hdec_pkg::ST_OK;
    case (in_item.func)
      hdec_pkg::FUNC_START: begin
        cmd_item.kind = hdec_pkg::CMD_START;
        cmd_push      = accept;
        if (accept) begin
          vlen_nxt  = cmd_item.value_len;
          cnt_nxt   = '0;
          rvcnt_nxt = '0;
          rvlen_nxt = CW'((rl9 > max9) ? max9 : rl9);
        end
      end
      hdec_pkg::FUNC_RV: begin
        cmd_item.kind = hdec_pkg::CMD_RV;
        if (rvcnt_r < rvlen_r) begin
          cmd_push = accept;
          if (accept) begin
            rvcnt_nxt = rvcnt_r + 1'b1;
          end
        end
      end
      hdec_pkg::FUNC_DATA: begin
        cmd_item.kind = hdec_pkg::CMD_DATA;
        if (cnt_r < vlen_r) begin
          cmd_push = accept;
          if (accept) begin
            cnt_nxt = cnt_r + 10'd1;
          end
        end
      end
      default: begin
        cmd_item.kind = hdec_pkg::CMD_DATA;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vlen_r  <= '0;
      cnt_r   <= '0;
      rvlen_r <= '0;
      rvcnt_r <= '0;
    end else begin
      vlen_r  <= vlen_nxt;
      cnt_r   <= cnt_nxt;
      rvlen_r <= rvlen_nxt;
      rvcnt_r <= rvcnt_nxt;
    end
  end

endmodule

/* rtl/core/hdec_md5.sv */
// ----------------------------------------------------------------------------
// hdec_md5
// Iterative MD5 compression, one round per cycle, byte-loaded block buffer.
// ----------------------------------------------------------------------------
module hdec_md5 (
  input  logic                clk,
  input  logic                rst_n,
  input  hdec_pkg::md5_ctl_t  ctl,
  output logic                done,
  output logic [127:0]        digest
);

  logic [31:0] m_r [16];
  logic [31:0] h_r [4];
  logic [31:0] a_r, b_r, c_r, d_r;
  logic [5:0]  i_r;
  logic        busy_r;
  logic [31:0] f, t, rot, b_n;
  logic [63:0] rot64;
  logic [31:0] base [4];

  assign done   = busy_r && (i_r == 6'd63);
  assign digest = {h_r[3], h_r[2], h_r[1], h_r[0]};

  always_comb begin
    case (i_r[5:4])
      2'd0:    f = (b_r & c_r) | (~b_r & d_r);
      2'd1:    f = (d_r & b_r) | (~d_r & c_r);
      2'd2:    f = b_r ^ c_r ^ d_r;
      default: f = c_r ^ (b_r | ~d_r);
    endcase
    t     = f + a_r + hdec_pkg::md5_k(i_r) + m_r[hdec_pkg::md5_g(i_r)];
    rot64 = {t, t} << hdec_pkg::md5_s(i_r);
    rot   = rot64[63:32];
    b_n   = b_r + rot;
    if (ctl.first) begin
      base[0] = hdec_pkg::MD5_IV0;
      base[1] = hdec_pkg::MD5_IV1;
      base[2] = hdec_pkg::MD5_IV2;
      base[3] = hdec_pkg::MD5_IV3;
    end else begin
      base = h_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      m_r[ctl.idx[5:2]][{ctl.idx[1:0], 3'b000} +: 8] <= ctl.wbyte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      i_r    <= '0;
      h_r[0] <= hdec_pkg::MD5_IV0;
      h_r[1] <= hdec_pkg::MD5_IV1;
      h_r[2] <= hdec_pkg::MD5_IV2;
      h_r[3] <= hdec_pkg::MD5_IV3;
    end else if (ctl.go) begin
      busy_r <= 1'b1;
      i_r    <= '0;
      h_r    <= base;
      a_r    <= base[0];
      b_r    <= base[1];
      c_r    <= base[2];
      d_r    <= base[3];
    end else if (busy_r) begin
      a_r <= d_r;
      b_r <= b_n;
      c_r <= b_r;
      d_r <= c_r;
      i_r <= i_r + 6'd1;
      if (done) begin
        busy_r <= 1'b0;
        h_r[0] <= h_r[0] + d_r;
        h_r[1] <= h_r[1] + b_n;
        h_r[2] <= h_r[2] + b_r;
        h_r[3] <= h_r[3] + c_r;
      end
    end
  end

endmodule

/* rtl/core/hdec_back.sv */
// ----------------------------------------------------------------------------
// hdec_back
// Executes queued commands: key generation, XOR decode, result beats.
// ----------------------------------------------------------------------------
module hdec_back #(
  parameter int MAX_RV_BYTES     = hdec_pkg::MAX_RV_BYTES,
  parameter int MAX_SECRET_BYTES = hdec_pkg::MAX_SECRET_BYTES
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cmd_empty,
  input  hdec_pkg::cmd_t       cmd_item,
  output logic                 cmd_pop,
  input  logic [63:0]          secret_low,
  input  logic [63:0]          secret_high,
  input  logic [4:0]           sec_nbytes,
  input  logic                 out_full,
  output logic                 out_push,
  output hdec_pkg::out_item_t  out_item
);

  localparam int AW = (MAX_RV_BYTES > 1) ? $clog2(MAX_RV_BYTES) : 1;
  localparam int CW = $clog2(MAX_RV_BYTES + 1);
  localparam int PW = $clog2(2 + MAX_SECRET_BYTES + MAX_RV_BYTES + 73);

  hdec_pkg::bk_state_t state_r, state_nxt;

  logic [7:0]        rv_mem [MAX_RV_BYTES];
  logic [7:0]        rv_q_r;
  logic [AW-1:0]     rd_addr;
  logic [CW-1:0]     rvc_r;
  logic [15:0]       type_r;
  logic [9:0]        vlen_r;
  hdec_pkg::status_t err_r, err_b;
  logic [15:0]       orig_r, ol;
  logic [7:0]        held_r;
  logic [127:0]      cur_r, key_r, sec;
  logic [9:0]        it_idx_r;
  logic              it_last_r;
  logic [7:0]        it_data_r;
  logic [PW-1:0]     len_r, total_r, p_r, len_c, sl_p, q_off;
  logic              first_r, key0_r;
  logic              fw_en_r, fw_rv_r;
  logic [5:0]        fw_idx_r;
  logic [7:0]        fw_byte_r, fill_byte;
  logic              fill_rv;
  logic [15:0]       bits16;
  hdec_pkg::out_item_t em2_r, res0, res1;
  hdec_pkg::md5_ctl_t  md5_ctl;
  logic              md5_done;
  logic [127:0]      digest;
  logic [4:0]        sl;
  logic              idle_take, need_hash, held_case, is_one, dec, proc_go;
  logic [3:0]        pos;
  logic [7:0]        d0, d1;

  assign sl   = (sec_nbytes > 5'(MAX_SECRET_BYTES)) ? 5'(MAX_SECRET_BYTES) : sec_nbytes;
  assign sl_p = PW'(sl);
  assign sec  = {secret_high, secret_low};

  assign idle_take = (state_r == hdec_pkg::BK_IDLE) && !cmd_empty;
  assign need_hash = (cmd_item.kind == hdec_pkg::CMD_DATA) &&
                     ((cmd_item.idx == 10'd0) ||
                      ((cmd_item.idx[3:0] == 4'd0) && (vlen_r > 10'(hdec_pkg::BLOCK_BYTES)) &&
                       (err_r == hdec_pkg::ST_OK)));
  assign len_c = (cmd_item.idx == 10'd0) ? (sl_p + PW'(rvc_r) + PW'(2))
                                         : (sl_p + PW'(hdec_pkg::BLOCK_BYTES));

  // message byte source for the current fill position
  always_comb begin
    fill_byte = 8'h00;
    fill_rv   = 1'b0;
    q_off     = p_r - sl_p - PW'(2);
    rd_addr   = q_off[AW-1:0];
    bits16    = 16'({len_r, 3'b000});
    if (p_r < len_r) begin
      if (key0_r) begin
        if (p_r == '0) begin
          fill_byte = type_r[15:8];
        end else if (p_r == PW'(1)) begin
          fill_byte = type_r[7:0];
        end else if (p_r < sl_p + PW'(2)) begin
          q_off     = p_r - PW'(2);
          fill_byte = sec[{q_off[3:0], 3'b000} +: 8];
        end else begin
          fill_rv = 1'b1;
        end
      end else if (p_r < sl_p) begin
        fill_byte = sec[{p_r[3:0], 3'b000} +: 8];
      end else begin
        q_off     = p_r - sl_p;
        fill_byte = cur_r[{q_off[3:0], 3'b000} +: 8];
      end
    end else if (p_r == len_r) begin
      fill_byte = 8'h80;
    end else if (p_r >= total_r - PW'(8)) begin
      q_off = p_r - (total_r - PW'(8));
      if (q_off == '0) begin
        fill_byte = bits16[7:0];
      end else if (q_off == PW'(1)) begin
        fill_byte = bits16[15:8];
      end
    end
  end

  // decode of the latched value byte
  always_comb begin
    pos       = it_idx_r[3:0];
    held_case = (it_idx_r == 10'd0) && (vlen_r >= 10'd2);
    is_one    = (it_idx_r == 10'd1);
    d0        = held_r ^ key_r[7:0];
    d1        = it_data_r ^ key_r[15:8];
    ol        = {d0, d1};
    err_b     = err_r;
    if ((err_r == hdec_pkg::ST_OK) && (vlen_r > 10'(hdec_pkg::BLOCK_BYTES)) &&
        (ol > (16'(vlen_r) - 16'd2))) begin
      err_b = hdec_pkg::ST_BIGLEN;
    end
    dec = (vlen_r <= 10'(hdec_pkg::BLOCK_BYTES)) || (it_idx_r < 10'(hdec_pkg::BLOCK_BYTES)) ||
          (17'(it_idx_r) < (17'(orig_r) + 17'd2));
    if (is_one) begin
      if (err_b == hdec_pkg::ST_OK) begin
        res0 = '{out_byte: d0, status: hdec_pkg::ST_OK, last: 1'b0};
        res1 = '{out_byte: d1, status: hdec_pkg::ST_OK, last: it_last_r};
      end else begin
        res0 = '{out_byte: held_r, status: err_b, last: 1'b0};
        res1 = '{out_byte: it_data_r, status: err_b, last: it_last_r};
      end
    end else begin
      res1 = '{out_byte: it_data_r, status: err_r, last: it_last_r};
      if (err_r != hdec_pkg::ST_OK) begin
        res0 = '{out_byte: it_data_r, status: err_r, last: it_last_r};
      end else begin
        res0 = '{out_byte: dec ? (it_data_r ^ key_r[{pos, 3'b000} +: 8]) : it_data_r,
                 status: hdec_pkg::ST_OK, last: it_last_r};
      end
    end
  end

  assign proc_go = (state_r == hdec_pkg::BK_PROC) && (held_case || !out_full);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      hdec_pkg::BK_IDLE: begin
        if (!cmd_empty && (cmd_item.kind == hdec_pkg::CMD_DATA)) begin
          state_nxt = need_hash ? hdec_pkg::BK_FILL : hdec_pkg::BK_PROC;
        end
      end
      hdec_pkg::BK_FILL: begin
        if (p_r[5:0] == 6'h3f) begin
          state_nxt = hdec_pkg::BK_FLUSH;
        end
      end
      hdec_pkg::BK_FLUSH: state_nxt = hdec_pkg::BK_GO;
      hdec_pkg::BK_GO:    state_nxt = hdec_pkg::BK_HASH;
      hdec_pkg::BK_HASH: begin
        if (md5_done) begin
          state_nxt = (p_r == total_r) ? hdec_pkg::BK_KEY : hdec_pkg::BK_FILL;
        end
      end
      hdec_pkg::BK_KEY: state_nxt = hdec_pkg::BK_PROC;
      hdec_pkg::BK_PROC: begin
        if (proc_go) begin
          state_nxt = (is_one && !held_case) ? hdec_pkg::BK_EMIT2 : hdec_pkg::BK_IDLE;
        end
      end
      hdec_pkg::BK_EMIT2: begin
        if (!out_full) begin
          state_nxt = hdec_pkg::BK_IDLE;
        end
      end
      default: state_nxt = hdec_pkg::BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_pop       = idle_take;
    md5_ctl.we    = fw_en_r;
    md5_ctl.idx   = fw_idx_r;
    md5_ctl.wbyte = fw_rv_r ? rv_q_r : fw_byte_r;
    md5_ctl.go    = (state_r == hdec_pkg::BK_GO);
    md5_ctl.first = first_r;
    out_push      = 1'b0;
    out_item      = res0;
    case (state_r)
      hdec_pkg::BK_PROC: out_push = proc_go && !held_case;
      hdec_pkg::BK_EMIT2: begin
        out_push = !out_full;
        out_item = em2_r;
      end
      default: out_push = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hdec_pkg::BK_IDLE;
      fw_en_r <= 1'b0;
      first_r <= 1'b0;
      rvc_r   <= '0;
      type_r  <= '0;
      vlen_r  <= '0;
      err_r   <= hdec_pkg::ST_OK;
      orig_r  <= '0;
      held_r  <= '0;
      cur_r   <= '0;
      key_r   <= '0;
    end else begin
      state_r <= state_nxt;
      fw_en_r <= (state_r == hdec_pkg::BK_FILL);
      if (idle_take) begin
        case (cmd_item.kind)
          hdec_pkg::CMD_START: begin
            type_r <= cmd_item.attr_type;
            vlen_r <= cmd_item.value_len;
            err_r  <= cmd_item.err;
            rvc_r  <= '0;
            orig_r <= '0;
            held_r <= '0;
            cur_r  <= '0;
          end
          hdec_pkg::CMD_RV: rvc_r <= rvc_r + 1'b1;
          default: begin
            if (need_hash) begin
              first_r <= 1'b1;
            end
          end
        endcase
      end
      if (state_r == hdec_pkg::BK_GO) begin
        first_r <= 1'b0;
      end
      if (state_r == hdec_pkg::BK_KEY) begin
        key_r <= digest;
      end
      if (proc_go) begin
        cur_r[{pos, 3'b000} +: 8] <= it_data_r;
        if (held_case) begin
          held_r <= it_data_r;
        end else if (is_one) begin
          err_r <= err_b;
          if ((err_r == hdec_pkg::ST_OK) && (vlen_r > 10'(hdec_pkg::BLOCK_BYTES))) begin
            orig_r <= ol;
          end
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    fw_idx_r  <= p_r[5:0];
    fw_rv_r   <= fill_rv;
    fw_byte_r <= fill_byte;
    if (proc_go) begin
      em2_r <= res1;
    end
    if (idle_take && (cmd_item.kind == hdec_pkg::CMD_DATA)) begin
      it_idx_r  <= cmd_item.idx;
      it_last_r <= cmd_item.last;
      it_data_r <= cmd_item.data;
      key0_r    <= (cmd_item.idx == 10'd0);
      len_r     <= len_c;
      total_r   <= PW'((((len_c + PW'(8)) >> 6) + PW'(1)) << 6);
      p_r       <= '0;
    end else if (state_r == hdec_pkg::BK_FILL) begin
      p_r <= p_r + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (idle_take && (cmd_item.kind == hdec_pkg::CMD_RV)) begin
      rv_mem[rvc_r[AW-1:0]] <= cmd_item.data;
    end
    rv_q_r <= rv_mem[rd_addr];
  end

  hdec_md5 u_md5 (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (md5_ctl),
    .done   (md5_done),
    .digest (digest)
  );

endmodule

/* rtl/core/hidden_avp_md5_decoder_top.sv */
// ----------------------------------------------------------------------------
// hidden_avp_md5_decoder_top
// L2TP hidden AVP value decoder with MD5 keystream.
// ----------------------------------------------------------------------------
// Input queue port: in_push/in_full carry start, RV and ciphered value beats.
// Result queue port: out_empty/out_pop; the head result sits on out_item.
// Config port: cfg_valid/cfg_ready (always ready), cfg_index, cfg_data;
// write only while the decoder is idle.
// A front stage frames each AVP and feeds a 2-deep command queue; the back
// stage decodes and writes a 2-deep result queue, so input is taken while
// results wait.
// Start and RV beats are taken in the idle state. A value byte that opens
// a key block (byte 0, and every 16th byte of long values with OK status)
// runs the MD5 unit: each 64-byte message block is loaded byte by byte,
// set up and hashed in 64 rounds, one or two blocks for key 0, one for
// later keys, and then the key is latched. Other value bytes go straight to
// processing; byte 1 also releases the held byte 0 result.
// The back stage takes a new command only from its idle state.
// Synchronous reset empties both queues and clears the secret registers.
// A stalled result side fills the queues and then raises in_full.
// ----------------------------------------------------------------------------
module hidden_avp_md5_decoder_top #(
  parameter int MAX_RV_BYTES     = hdec_pkg::MAX_RV_BYTES,
  parameter int MAX_SECRET_BYTES = hdec_pkg::MAX_SECRET_BYTES
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_push,
  input  hdec_pkg::in_item_t                 in_item,
  output logic                               in_full,
  output logic                               out_empty,
  input  logic                               out_pop,
  output hdec_pkg::out_item_t                out_item,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [hdec_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [63:0]                        cfg_data
);

  logic [63:0] secret_low_r, secret_high_r;
  logic [4:0]  sec_nbytes_r;

  logic                cmd_push, cmd_full, cmd_empty, cmd_pop;
  hdec_pkg::cmd_t      cmd_w, cmd_r;
  logic                res_push, res_full;
  hdec_pkg::out_item_t res_w;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      secret_low_r  <= '0;
      secret_high_r <= '0;
      sec_nbytes_r  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        hdec_pkg::CFG_SECRET_LOW:  secret_low_r  <= cfg_data;
        hdec_pkg::CFG_SECRET_HIGH: secret_high_r <= cfg_data;
        hdec_pkg::CFG_SECRET_LEN:  sec_nbytes_r  <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  hdec_front #(
    .MAX_RV_BYTES (MAX_RV_BYTES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_item  (in_item),
    .in_full  (in_full),
    .cmd_push (cmd_push),
    .cmd_item (cmd_w),
    .cmd_full (cmd_full)
  );

  hdec_fifo #(
    .W     ($bits(hdec_pkg::cmd_t)),
    .DEPTH (hdec_pkg::QUEUE_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (cmd_w),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_r),
    .empty (cmd_empty)
  );

  hdec_back #(
    .MAX_RV_BYTES     (MAX_RV_BYTES),
    .MAX_SECRET_BYTES (MAX_SECRET_BYTES)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_empty   (cmd_empty),
    .cmd_item    (cmd_r),
    .cmd_pop     (cmd_pop),
    .secret_low  (secret_low_r),
    .secret_high (secret_high_r),
    .sec_nbytes  (sec_nbytes_r),
    .out_full    (res_full),
    .out_push    (res_push),
    .out_item    (res_w)
  );

  hdec_fifo #(
    .W     ($bits(hdec_pkg::out_item_t)),
    .DEPTH (hdec_pkg::QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_w),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (out_item),
    .empty (out_empty)
  );

endmodule

/* rtl/core/hdec_checker.sv */
// ----------------------------------------------------------------------------
// hdec_checker
// Port-level checks for the hidden AVP decoder, bound to the top level.
// ----------------------------------------------------------------------------
module hdec_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_push,
  input hdec_pkg::in_item_t             in_item,
  input logic                           in_full,
  input logic                           out_empty,
  input logic                           out_pop,
  input hdec_pkg::out_item_t            out_item,
  input logic                           cfg_valid,
  input logic                           cfg_ready,
  input logic [hdec_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [63:0]                    cfg_data
);

  a_empty_after_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> out_empty)
    else $error("result queue not empty after reset");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_item.status == hdec_pkg::ST_OK ||
                    out_item.status == hdec_pkg::ST_SHORT ||
                    out_item.status == hdec_pkg::ST_BIGLEN))
    else $error("bad status code");

  a_head_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> $stable(out_item))
    else $error("head result changed while stalled");

  a_head_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> !out_empty)
    else $error("result dropped while stalled");

endmodule

bind hidden_avp_md5_decoder_top hdec_checker u_hdec_checker (.*);

/* verif/hidden_avp_md5_decoder_top_test.sv */
// ----------------------------------------------------------------------------
// hidden_avp_md5_decoder_top_test
// Self-checking bench for the hidden AVP decoder: a scoreboard class keeps its
// own MD5 keystream model and predicts every decoded byte, status and last
// flag; tasks push framed AVPs and noise under random stalls on both sides.
// ----------------------------------------------------------------------------
module hidden_avp_md5_decoder_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_WAIT  = 400;
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  class avp_plain_scoreboard;
    bit [63:0]           sec_lo, sec_hi;
    bit [4:0]            sec_len;
    bit [7:0]            rv_mem[hdec_pkg::MAX_RV_BYTES];
    int                  rv_len, rv_cnt;
    bit [15:0]           typ;
    int                  vlen, bcnt, olen;
    hdec_pkg::status_t   err;
    bit [7:0]            key[16], cur[16];
    bit [7:0]            held;
    hdec_pkg::out_item_t pending_out[$];
    bit [31:0]           rk[64];
    int                  rs[16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
    int                  n_bad, n_ok;

    function new();
      for (int i = 0; i < 64; i++)
        rk[i] = 32'(longint'($floor($sin(real'(i + 1)) < 0
                                    ? -$sin(real'(i + 1)) * 4294967296.0
                                    : $sin(real'(i + 1)) * 4294967296.0)));
      err = hdec_pkg::ST_OK;
    endfunction

    function bit [127:0] md5_sum(bit [7:0] msg[128], int len);
      int          total;
      bit [63:0]   bits;
      bit [31:0]   h[4], m[16], a, b, c, d, f, t;
      bit [7:0]    buf8[64];
      int          p, g;
      bit [127:0]  dig;
      total = ((len + 8) / 64 + 1) * 64;
      bits = 64'(len) * 8;
      h = '{32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476};
      for (int blk = 0; blk < total; blk += 64) begin
        for (int j = 0; j < 64; j++) begin
          p = blk + j;
          if (p < len) buf8[j] = msg[p];
          else if (p == len) buf8[j] = 8'h80;
          else if (p >= total - 8) buf8[j] = 8'(bits >> (8 * (p - (total - 8))));
          else buf8[j] = 8'h00;
        end
        for (int j = 0; j < 16; j++)
          m[j] = {buf8[4*j+3], buf8[4*j+2], buf8[4*j+1], buf8[4*j]};
        a = h[0]; b = h[1]; c = h[2]; d = h[3];
        for (int i = 0; i < 64; i++) begin
          if (i < 16) begin f = (b & c) | (~b & d); g = i; end
          else if (i < 32) begin f = (d & b) | (~d & c); g = (5 * i + 1) % 16; end
          else if (i < 48) begin f = b ^ c ^ d; g = (3 * i + 5) % 16; end
          else begin f = c ^ (b | ~d); g = (7 * i) % 16; end
          t = f + a + rk[i] + m[g];
          a = d; d = c; c = b;
          b = b + ((t << rs[(i / 16) * 4 + i % 4]) | (t >> (32 - rs[(i / 16) * 4 + i % 4])));
        end
        h[0] += a; h[1] += b; h[2] += c; h[3] += d;
      end
      for (int j = 0; j < 16; j++) dig[8*j +: 8] = h[j / 4][8 * (j % 4) +: 8];
      return dig;
    endfunction

    function int put_secret(ref bit [7:0] msg[128], input int pos);
      int n;
      n = (sec_len > 16) ? 16 : sec_len;
      for (int i = 0; i < n; i++) msg[pos++] = (i < 8) ? sec_lo[8*i +: 8] : sec_hi[8*(i-8) +: 8];
      return pos;
    endfunction

    function bit [127:0] key_zero(bit [15:0] t, bit [7:0] rvq[$]);
      bit [7:0] msg[128];
      int       n;
      msg[0] = t[15:8]; msg[1] = t[7:0];
      n = put_secret(msg, 2);
      foreach (rvq[r]) msg[n++] = rvq[r];
      return md5_sum(msg, n);
    endfunction

    function void set_reg(bit [hdec_pkg::CFG_IDX_W-1:0] idx, bit [63:0] val);
      if (idx == hdec_pkg::CFG_SECRET_LOW) sec_lo = val;
      else if (idx == hdec_pkg::CFG_SECRET_HIGH) sec_hi = val;
      else if (idx == hdec_pkg::CFG_SECRET_LEN) sec_len = val[4:0];
    endfunction

    function void add_out(bit [7:0] b, hdec_pkg::status_t st, bit lst);
      hdec_pkg::out_item_t o;
      o.out_byte = b; o.status = st; o.last = lst;
      pending_out.push_back(o);
    endfunction

    function void absorb_beat(hdec_pkg::in_item_t it);
      bit [7:0]   msg[128];
      bit [127:0] k;
      bit [7:0]   c, d0, d1;
      int         i, pos, n, lim;
      bit         lst;
      bit [7:0]   rvq[$];
      c = it.data_byte;
      if (it.func == hdec_pkg::FUNC_START) begin
        typ = it.attr_type;
        vlen = (it.avp_length >= hdec_pkg::HEADER_BYTES) ?
               it.avp_length - hdec_pkg::HEADER_BYTES : 0;
        err = (it.avp_length < hdec_pkg::HEADER_BYTES + 2) ? hdec_pkg::ST_SHORT
                                                           : hdec_pkg::ST_OK;
        rv_len = (it.rv_length > hdec_pkg::MAX_RV_BYTES) ? hdec_pkg::MAX_RV_BYTES
                                                         : it.rv_length;
        rv_cnt = 0; bcnt = 0; olen = 0; held = 0;
        foreach (cur[j]) cur[j] = 0;
        return;
      end
      if (it.func == hdec_pkg::FUNC_RV) begin
        if (rv_cnt < rv_len) rv_mem[rv_cnt++] = c;
        return;
      end
      if (it.func != hdec_pkg::FUNC_DATA || bcnt >= vlen) return;
      i = bcnt++;
      lst = (i + 1 == vlen);
      pos = i % hdec_pkg::BLOCK_BYTES;
      if (i == 0) begin
        for (int r = 0; r < rv_cnt; r++) rvq.push_back(rv_mem[r]);
        k = key_zero(typ, rvq);
        foreach (key[j]) key[j] = k[8*j +: 8];
      end else if (pos == 0 && vlen > hdec_pkg::BLOCK_BYTES && err == hdec_pkg::ST_OK) begin
        n = put_secret(msg, 0);
        for (int j = 0; j < 16; j++) msg[n + j] = cur[j];
        k = md5_sum(msg, n + 16);
        foreach (key[j]) key[j] = k[8*j +: 8];
      end
      cur[pos] = c;
      if (i == 0 && vlen >= 2) begin
        held = c;
        return;
      end
      if (i == 1) begin
        if (err == hdec_pkg::ST_OK) begin
          d0 = held ^ key[0]; d1 = c ^ key[1];
          if (vlen > hdec_pkg::BLOCK_BYTES) begin
            olen = {d0, d1};
            if (olen > vlen - 2) err = hdec_pkg::ST_BIGLEN;
          end
          if (err == hdec_pkg::ST_OK) begin
            add_out(d0, hdec_pkg::ST_OK, 0);
            add_out(d1, hdec_pkg::ST_OK, lst);
            return;
          end
        end
        add_out(held, err, 0);
        add_out(c, err, lst);
        return;
      end
      if (err != hdec_pkg::ST_OK) begin
        add_out(c, err, lst);
        return;
      end
      lim = (olen + 2 < hdec_pkg::BLOCK_BYTES) ? hdec_pkg::BLOCK_BYTES : olen + 2;
      if (vlen <= hdec_pkg::BLOCK_BYTES || i < lim) c ^= key[pos];
      add_out(c, hdec_pkg::ST_OK, lst);
    endfunction

    function void check_beat(hdec_pkg::out_item_t got);
      hdec_pkg::out_item_t want;
      if (pending_out.size() == 0) begin
        n_bad++;
        if (n_bad <= 10)
          $display("unexpected beat: byte %02h status %0d last %0b",
                   got.out_byte, got.status, got.last);
        return;
      end
      want = pending_out.pop_front();
      if (got.out_byte !== want.out_byte || got.status !== want.status
          || got.last !== want.last) begin
        n_bad++;
        if (n_bad <= 10)
          $display("beat mismatch: want %02h/%0d/%0b got %02h/%0d/%0b",
                   want.out_byte, want.status, want.last,
                   got.out_byte, got.status, got.last);
      end else
        n_ok++;
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_push = 1'b0;
  hdec_pkg::in_item_t             in_item = '0;
  logic                           in_full;
  logic                           out_empty;
  logic                           out_pop = 1'b0;
  hdec_pkg::out_item_t            out_item;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [hdec_pkg::CFG_IDX_W-1:0] cfg_index = hdec_pkg::CFG_SECRET_LOW;
  logic [63:0]                    cfg_data = '0;

  avp_plain_scoreboard sb = new();
  int  tx_idle = 20, rx_idle = 20;
  bit  hold_req = 0, hold_done = 0;
  int  hold_cnt = 0;
  int  cyc = 0, sent = 0, avps = 0, n_cfg = 0;

  hidden_avp_md5_decoder_top DUT (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cyc++;
    if (cyc > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cyc);
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) if (rst_n) begin
    if (in_push && !in_full) sb.absorb_beat(in_item);
    if (out_pop && !out_empty) sb.check_beat(out_item);
    if (cfg_valid && cfg_ready) sb.set_reg(cfg_index, cfg_data);
  end

  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_cnt <= 600;
      out_pop <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_pop <= 1'b0;
    end else
      out_pop <= rst_n && ($urandom_range(99) >= rx_idle);
  end

  task automatic push_beat(hdec_pkg::in_item_t it);
    while ($urandom_range(99) < tx_idle) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_full) @(posedge clk);
    sent++;
  endtask

  task automatic drain();
    in_push <= 1'b0;
    @(posedge clk);
    while (sb.pending_out.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(bit [hdec_pkg::CFG_IDX_W-1:0] idx, bit [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    n_cfg++;
  endtask

  task automatic set_secret(bit [63:0] lo, bit [63:0] hi, bit [4:0] len);
    drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    write_reg(hdec_pkg::CFG_SECRET_LOW, lo);
    write_reg(hdec_pkg::CFG_SECRET_HIGH, hi);
    write_reg(hdec_pkg::CFG_SECRET_LEN, 64'(len));
  endtask

  function automatic hdec_pkg::in_item_t rand_item(logic [1:0] f);
    hdec_pkg::in_item_t it;
    logic [63:0]        r;
    r = {$urandom, $urandom};
    it = r[$bits(hdec_pkg::in_item_t)-1:0];
    it.func = f;
    return it;
  endfunction

  // one framed AVP; good picks an original length that fits the value
  task automatic send_avp(int alen, int rl, int rv_sent, int val_sent, bit good);
    hdec_pkg::in_item_t it;
    bit [7:0]           rvq[$];
    bit [127:0]         k;
    bit [15:0]          ol;
    int                 vl;
    bit [7:0]           b;
    it = rand_item(hdec_pkg::FUNC_START);
    if ($urandom_range(9) == 0) it.attr_type = $urandom_range(1) ? 16'hffff : 16'h0000;
    it.avp_length = 10'(alen);
    it.rv_length = 7'(rl);
    push_beat(it);
    for (int r = 0; r < rv_sent; r++) begin
      it = rand_item(hdec_pkg::FUNC_RV);
      if (r < rl && r < hdec_pkg::MAX_RV_BYTES) rvq.push_back(it.data_byte);
      push_beat(it);
    end
    vl = (alen >= hdec_pkg::HEADER_BYTES) ? alen - hdec_pkg::HEADER_BYTES : 0;
    k = sb.key_zero(sb.typ, rvq);
    ol = (vl > 2) ? 16'($urandom_range(vl - 2)) : 16'h0;
    for (int v = 0; v < val_sent; v++) begin
      it = rand_item(hdec_pkg::FUNC_DATA);
      if (good && vl > hdec_pkg::BLOCK_BYTES && v < 2) begin
        b = (v == 0) ? ol[15:8] : ol[7:0];
        it.data_byte = b ^ k[8*v +: 8];
      end
      push_beat(it);
    end
    avps++;
  endtask

  task automatic random_phase(int n_items);
    int stop, alen, rl, rv_sent, vl, val_sent, sel, room;
    stop = sent + n_items;
    while (sent < stop) begin
      sel = $urandom_range(99);
      if (sel < 5) push_beat(rand_item(FUNC_SPARE));
      else if (sel < 8) push_beat(rand_item(hdec_pkg::FUNC_DATA));
      sel = $urandom_range(99);
      if (sel < 60) alen = 6 + $urandom_range(16);
      else if (sel < 70) alen = $urandom_range(7);
      else if (sel < 98) alen = 23 + $urandom_range(60);
      else alen = $urandom_range(1) ? 1023 : $urandom_range(300, 1023);
      rl = ($urandom_range(19) == 0) ? $urandom_range(64, 127) : $urandom_range(20);
      rv_sent = (rl > hdec_pkg::MAX_RV_BYTES) ? hdec_pkg::MAX_RV_BYTES : rl;
      sel = $urandom_range(19);
      if (sel == 0) rv_sent = $urandom_range(rv_sent);
      else if (sel == 1) rv_sent = rv_sent + $urandom_range(1, 3);
      vl = (alen >= hdec_pkg::HEADER_BYTES) ? alen - hdec_pkg::HEADER_BYTES : 0;
      sel = $urandom_range(9);
      val_sent = (sel == 0) ? vl + $urandom_range(1, 3) : (sel == 1) ? $urandom_range(vl) : vl;
      // keep the phase near its item budget
      room = stop - sent - 1 - rv_sent;
      if (room < 8) room = 8;
      if (val_sent > room) val_sent = room;
      send_avp(alen, rl, rv_sent, val_sent, $urandom_range(99) < 85);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: stray beats, short, tiny, whole-block and long values
    push_beat(rand_item(hdec_pkg::FUNC_DATA));
    push_beat(rand_item(FUNC_SPARE));
    send_avp(3, 0, 0, 2, 1);
    send_avp(7, 0, 0, 1, 1);
    send_avp(8, 1, 1, 2, 1);
    send_avp(22, 127, 2, 16, 1);
    send_avp(23, 2, 1, 17, 1);
    send_avp(23, 0, 0, 17, 0);

    set_secret('0, '0, 5'd0);
    random_phase(150);
    set_secret('1, '1, 5'd16);
    tx_idle = 0;
    rx_idle = 0;
    random_phase(60);
    tx_idle = 20;
    rx_idle = 20;
    hold_req <= 1'b1;
    random_phase(150);
    set_secret({$urandom, $urandom}, {$urandom, $urandom}, 5'($urandom_range(1, 15)));
    random_phase(120);
    drain();
    random_phase(100);
    set_secret({$urandom, $urandom}, {$urandom, $urandom}, 5'd31);
    random_phase(220);
    set_secret({$urandom, $urandom}, {$urandom, $urandom}, 5'($urandom_range(16)));
    random_phase(220);

    drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("covered %0d beats in %0d AVPs, %0d register writes, %0d results checked",
             sent, avps, n_cfg, sb.n_ok + sb.n_bad);
    if (sb.n_bad == 0 && sb.pending_out.size() == 0)
      $display("No mismatches found");
    else begin
      $display("%0d mismatches, %0d results never seen", sb.n_bad, sb.pending_out.size());
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
